>>> src/drd_pkg.sv
// Shared types, register indexes and constants for the detector row decoder.
// Used by every module of the block; depends on nothing else.
package drd_pkg;

   localparam int DEF_MAX_CLASSES    = 16;
   localparam int DEF_MAX_CANDIDATES = 16384;
   localparam int ROWQ_DEPTH         = 4;
   localparam int RSPQ_DEPTH         = 4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_COUNT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONF_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_MASK     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 3'd6;

   // Largest frame side that clipping honors.
   localparam logic [13:0] FRAME_LIMIT = 14'd4096;

   typedef struct packed {
      logic [4:0]  class_count;
      logic [12:0] confidence_threshold;
      logic [15:0] accepted_class_mask;
      logic [15:0] scale_x;
      logic [15:0] scale_y;
      logic [12:0] frame_width;
      logic [12:0] frame_height;
   } cfg_type;

   // One kept candidate handed from the front end to the back end.
   typedef struct packed {
      logic [13:0]        candidate_index;
      logic signed [23:0] center_x;
      logic signed [23:0] center_y;
      logic signed [23:0] width;
      logic signed [23:0] height;
      logic [3:0]         class_index;
      logic [22:0]        score;
   } row_type;

   typedef struct packed {
      logic [13:0] candidate_index;
      logic [11:0] box_x;
      logic [11:0] box_y;
      logic [12:0] box_width;
      logic [12:0] box_height;
      logic [3:0]  class_index;
      logic [22:0] score;
   } rsp_type;

   // Shift right by sh with rounding half away from zero.
   function automatic logic signed [19:0] round_shift(input logic signed [42:0] p,
                                                      input int sh);
      logic [42:0] mag;
      logic [42:0] r;
      mag = p[42] ? 43'(-p) : 43'(p);
      r = (mag + (43'd1 << (sh - 1))) >> sh;
      return p[42] ? -$signed(20'(r)) : $signed(20'(r));
   endfunction

endpackage

>>> src/detector_row_decode.sv
// Top level of the detector row decoder: register file, front end, row queue,
// back end and result queue. Depends on drd_pkg, drd_fifo, drd_front, drd_back.

// The block takes head output values row by row: four box values (center x,
// center y, width, height) and then class_count scores, all signed with 12
// fraction bits; frame_start on a value makes it center x of row 0. A
// continuous stream runs at one value per clock while req_full is low. A kept
// candidate leaves the front end at its row's last value and enters a
// four-entry row queue; the back end scales, rounds and clips it in three
// pipeline stages and writes it to a four-entry result queue, so a box reaches
// the rsp_ ports through the row queue, the three back-end stages and the
// result queue. Since rows are at least four values long the back end always
// keeps pace; req_full rises only when the row queue fills because results
// are not being popped. Write the registers only while the block is idle.
module detector_row_decode #(
   parameter int MAX_CLASSES    = drd_pkg::DEF_MAX_CLASSES,
   parameter int MAX_CANDIDATES = drd_pkg::DEF_MAX_CANDIDATES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic signed [23:0]              req_value,
   input  logic                            req_frame_start,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [13:0]                     rsp_candidate_index,
   output logic [11:0]                     rsp_box_x,
   output logic [11:0]                     rsp_box_y,
   output logic [12:0]                     rsp_box_width,
   output logic [12:0]                     rsp_box_height,
   output logic [3:0]                      rsp_class_index,
   output logic [22:0]                     rsp_score,
   input  logic                            csr_write_enable,
   input  logic [drd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [drd_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import drd_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    accept;
   logic    front_push;
   row_type front_row;
   logic    rowq_full, rowq_valid, rowq_pop;
   row_type rowq_row;
   logic    back_push;
   rsp_type back_rsp;
   logic    rspq_full, rspq_valid;
   rsp_type rspq_rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CLASS_COUNT:    cfg_in.class_count          = csr_write_data[4:0];
            CSR_CONF_THRESHOLD: cfg_in.confidence_threshold = csr_write_data[12:0];
            CSR_CLASS_MASK:     cfg_in.accepted_class_mask  = csr_write_data;
            CSR_SCALE_X:        cfg_in.scale_x              = csr_write_data;
            CSR_SCALE_Y:        cfg_in.scale_y              = csr_write_data;
            CSR_FRAME_WIDTH:    cfg_in.frame_width          = csr_write_data[12:0];
            CSR_FRAME_HEIGHT:   cfg_in.frame_height         = csr_write_data[12:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.class_count          <= 5'd4;
         cfg_ff.confidence_threshold <= 13'd1024;
         cfg_ff.accepted_class_mask  <= 16'd15;
         cfg_ff.scale_x              <= 16'd4096;
         cfg_ff.scale_y              <= 16'd4096;
         cfg_ff.frame_width          <= 13'd1920;
         cfg_ff.frame_height         <= 13'd1080;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = rowq_full;
   assign accept   = req_push & ~req_full;

   drd_front #(
      .MAX_CLASSES    (MAX_CLASSES),
      .MAX_CANDIDATES (MAX_CANDIDATES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (accept),
      .value       (req_value),
      .frame_start (req_frame_start),
      .row_push    (front_push),
      .row         (front_row)
   );

   drd_fifo #(
      .WIDTH ($bits(row_type)),
      .DEPTH (ROWQ_DEPTH)
   ) u_rowq (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_row),
      .full      (rowq_full),
      .pop       (rowq_pop),
      .pop_data  (rowq_row),
      .valid     (rowq_valid)
   );

   drd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .row_valid (rowq_valid),
      .row       (rowq_row),
      .row_pop   (rowq_pop),
      .rsp_push  (back_push),
      .rsp       (back_rsp),
      .rsp_full  (rspq_full)
   );

   drd_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSPQ_DEPTH)
   ) u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (rspq_full),
      .pop       (rsp_pop),
      .pop_data  (rspq_rsp),
      .valid     (rspq_valid)
   );

   assign rsp_empty           = ~rspq_valid;
   assign rsp_candidate_index = rspq_rsp.candidate_index;
   assign rsp_box_x           = rspq_rsp.box_x;
   assign rsp_box_y           = rspq_rsp.box_y;
   assign rsp_box_width       = rspq_rsp.box_width;
   assign rsp_box_height      = rspq_rsp.box_height;
   assign rsp_class_index     = rspq_rsp.class_index;
   assign rsp_score           = rspq_rsp.score;

endmodule

>>> src/drd_fifo.sv
// Small first-in first-out queue built from flip-flops.
// Used for the row queue and the result queue; depends on drd_pkg for defaults.
module drd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = drd_pkg::ROWQ_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & valid;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The surrounding logic must never offer a word the queue cannot take.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue pushed while full");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count ran past its depth");

endmodule

>>> src/drd_front.sv
// Front end: walks each row of head values, keeps the box and a running argmax,
// and at the row's last value decides whether the candidate goes on. Uses drd_pkg.
module drd_front #(
   parameter int MAX_CLASSES    = drd_pkg::DEF_MAX_CLASSES,
   parameter int MAX_CANDIDATES = drd_pkg::DEF_MAX_CANDIDATES
) (
   input  logic               clock,
   input  logic               reset,
   input  drd_pkg::cfg_type   cfg,
   input  logic               accept,
   input  logic signed [23:0] value,
   input  logic               frame_start,
   output logic               row_push,
   output drd_pkg::row_type   row
);
   import drd_pkg::*;

   localparam int POS_W  = $clog2(MAX_CLASSES + 5);
   localparam int CAND_W = $clog2(MAX_CANDIDATES);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CAND_W-1:0]  cand_ff, cand_in;
   logic signed [23:0] box_ff [4];
   logic signed [23:0] best_ff, best_in;
   logic [POS_W-1:0]   cls_ff, cls_in;
   logic               best_valid_ff, best_valid_in;

   logic [POS_W-1:0]   pos_cur, cc, row_len;
   logic [CAND_W-1:0]  cand_cur;
   logic signed [23:0] best_cur;
   logic [POS_W-1:0]   cls_cur;
   logic               best_valid_cur;
   logic               last, keep;

   always_comb begin
      // A frame start restarts counting and the argmax before this value is used.
      pos_cur        = frame_start ? '0 : pos_ff;
      cand_cur       = frame_start ? '0 : cand_ff;
      best_cur       = frame_start ? '0 : best_ff;
      cls_cur        = frame_start ? '1 : cls_ff;
      best_valid_cur = frame_start ? 1'b0 : best_valid_ff;

      cc = (32'(cfg.class_count) > MAX_CLASSES) ? POS_W'(MAX_CLASSES)
                                                : POS_W'(cfg.class_count);
      row_len = cc + POS_W'(4);

      best_in       = best_cur;
      cls_in        = cls_cur;
      best_valid_in = best_valid_cur;
      if (pos_cur >= POS_W'(4) && value > best_cur) begin
         best_in       = value;
         cls_in        = pos_cur - POS_W'(4);
         best_valid_in = 1'b1;
      end

      last = (pos_cur >= row_len - POS_W'(1));
      keep = (cc >= POS_W'(2)) && best_valid_in &&
             ($signed({1'b0, best_in}) >= $signed(25'(cfg.confidence_threshold))) &&
             (32'(cls_in) < 32'd16) &&
             cfg.accepted_class_mask[4'(cls_in)];

      pos_in  = pos_cur + POS_W'(1);
      cand_in = cand_cur;
      if (last) begin
         pos_in        = '0;
         cand_in       = (cand_cur == CAND_W'(MAX_CANDIDATES - 1)) ? '0 : cand_cur + 1'b1;
         best_in       = '0;
         cls_in        = '1;
         best_valid_in = 1'b0;
      end
   end

   assign row_push = accept & last & keep;

   always_comb begin
      row.candidate_index = 14'(cand_cur);
      row.center_x        = box_ff[0];
      row.center_y        = box_ff[1];
      row.width           = box_ff[2];
      row.height          = box_ff[3];
      row.class_index     = 4'(cls_in);
      row.score           = best_in[22:0];
      // The argmax is cleared at the row end, so take the class and score
      // before clearing.
      if (pos_cur >= POS_W'(4) && value > best_cur) begin
         row.class_index = 4'(pos_cur - POS_W'(4));
         row.score       = value[22:0];
      end else begin
         row.class_index = 4'(cls_cur);
         row.score       = best_cur[22:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         cand_ff       <= '0;
         best_ff       <= '0;
         cls_ff        <= '1;
         best_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            box_ff[i] <= '0;
         end
      end else if (accept) begin
         pos_ff        <= pos_in;
         cand_ff       <= cand_in;
         best_ff       <= best_in;
         cls_ff        <= cls_in;
         best_valid_ff <= best_valid_in;
         if (pos_cur < POS_W'(4)) begin
            box_ff[2'(pos_cur)] <= value;
         end
      end
   end

   a_pos_in_row: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_CLASSES + 3))
      else $error("row position ran past the longest row");

endmodule

>>> src/drd_back.sv
// Back end: scales a kept candidate's box to frame pixels, rounds, clips and
// drops empty boxes, in three register stages. Uses drd_pkg.
module drd_back (
   input  logic             clock,
   input  logic             reset,
   input  drd_pkg::cfg_type cfg,
   input  logic             row_valid,
   input  drd_pkg::row_type row,
   output logic             row_pop,
   output logic             rsp_push,
   output drd_pkg::rsp_type rsp,
   input  logic             rsp_full
);
   import drd_pkg::*;

   // Stage 1: products.
   logic               s1_valid_ff, s1_valid_in;
   logic signed [42:0] s1_px_ff, s1_py_ff, s1_pw_ff, s1_ph_ff;
   logic [13:0]        s1_cand_ff;
   logic [3:0]         s1_cls_ff;
   logic [22:0]        s1_score_ff;
   // Stage 2: rounded pixel coordinates.
   logic               s2_valid_ff, s2_valid_in;
   logic signed [19:0] s2_lx_ff, s2_ty_ff, s2_bw_ff, s2_bh_ff;
   logic [13:0]        s2_cand_ff;
   logic [3:0]         s2_cls_ff;
   logic [22:0]        s2_score_ff;
   // Stage 3: clipped box.
   logic               s3_valid_ff, s3_valid_in;
   logic               s3_ok_ff, s3_ok_in;
   rsp_type            s3_rsp_ff, s3_rsp_in;

   logic               go1, go2, go3;
   logic signed [25:0] dx, dy;
   logic signed [16:0] sx, sy;
   logic signed [42:0] px_in, py_in, pw_in, ph_in;
   logic signed [19:0] lx_in, ty_in, bw_in, bh_in;
   logic signed [19:0] frame_w, frame_h, x1, y1, x2, y2, x2_raw, y2_raw;

   assign go3         = ~s3_valid_ff | ~s3_ok_ff | ~rsp_full;
   assign go2         = ~s2_valid_ff | go3;
   assign go1         = ~s1_valid_ff | go2;
   assign row_pop     = row_valid & go1;
   assign s1_valid_in = go1 ? row_valid : s1_valid_ff;
   assign s2_valid_in = go2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = go3 ? s2_valid_ff : s3_valid_ff;
   assign rsp_push    = s3_valid_ff & s3_ok_ff & ~rsp_full;
   assign rsp         = s3_rsp_ff;

   always_comb begin
      sx    = $signed({1'b0, cfg.scale_x});
      sy    = $signed({1'b0, cfg.scale_y});
      dx    = (26'(row.center_x) <<< 1) - 26'(row.width);
      dy    = (26'(row.center_y) <<< 1) - 26'(row.height);
      px_in = 43'(dx) * 43'(sx);
      py_in = 43'(dy) * 43'(sy);
      pw_in = 43'(row.width) * 43'(sx);
      ph_in = 43'(row.height) * 43'(sy);
   end

   always_comb begin
      lx_in = round_shift(s1_px_ff, 25);
      ty_in = round_shift(s1_py_ff, 25);
      bw_in = round_shift(s1_pw_ff, 24);
      bh_in = round_shift(s1_ph_ff, 24);
   end

   always_comb begin
      frame_w = (14'(cfg.frame_width) > FRAME_LIMIT) ? 20'(FRAME_LIMIT)
                                                      : 20'(cfg.frame_width);
      frame_h = (14'(cfg.frame_height) > FRAME_LIMIT) ? 20'(FRAME_LIMIT)
                                                       : 20'(cfg.frame_height);
      x1      = (s2_lx_ff > 20'sd0) ? s2_lx_ff : 20'sd0;
      y1      = (s2_ty_ff > 20'sd0) ? s2_ty_ff : 20'sd0;
      x2_raw  = s2_lx_ff + s2_bw_ff;
      y2_raw  = s2_ty_ff + s2_bh_ff;
      x2      = (x2_raw < frame_w) ? x2_raw : frame_w;
      y2      = (y2_raw < frame_h) ? y2_raw : frame_h;
      s3_ok_in = (s2_bw_ff > 20'sd0) && (s2_bh_ff > 20'sd0) && (x2 > x1) && (y2 > y1);
      s3_rsp_in.candidate_index = s2_cand_ff;
      s3_rsp_in.box_x           = x1[11:0];
      s3_rsp_in.box_y           = y1[11:0];
      s3_rsp_in.box_width       = 13'(x2 - x1);
      s3_rsp_in.box_height      = 13'(y2 - y1);
      s3_rsp_in.class_index     = s2_cls_ff;
      s3_rsp_in.score           = s2_score_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s3_ok_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         if (go3) begin
            s3_ok_ff <= s3_ok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go1) begin
         s1_px_ff    <= px_in;
         s1_py_ff    <= py_in;
         s1_pw_ff    <= pw_in;
         s1_ph_ff    <= ph_in;
         s1_cand_ff  <= row.candidate_index;
         s1_cls_ff   <= row.class_index;
         s1_score_ff <= row.score;
      end
      if (go2) begin
         s2_lx_ff    <= lx_in;
         s2_ty_ff    <= ty_in;
         s2_bw_ff    <= bw_in;
         s2_bh_ff    <= bh_in;
         s2_cand_ff  <= s1_cand_ff;
         s2_cls_ff   <= s1_cls_ff;
         s2_score_ff <= s1_score_ff;
      end
      if (go3) begin
         s3_rsp_ff <= s3_rsp_in;
      end
   end

   // A box that leaves the back end is non-empty and lies within FRAME_LIMIT on both axes.
   a_box_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (rsp.box_width != '0) && (rsp.box_height != '0) &&
                   (14'(rsp.box_x) + 14'(rsp.box_width) <= FRAME_LIMIT) &&
                   (14'(rsp.box_y) + 14'(rsp.box_height) <= FRAME_LIMIT))
      else $error("emitted box is empty or outside the frame");

endmodule
